### hw/rtl/wfmc_pkg.sv
`timescale 1ns / 1ps

package wfmc_pkg;

    localparam int SENSOR_BITS_DEF = 12;
    localparam int SPEED_BITS_DEF  = 10;

    localparam int GAIN_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CHAR_W     = 8;
    localparam int REPLY_W    = 2;
    localparam int CORR_W     = 12;
    localparam int LIMIT_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIDE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_WALL_LEVEL = 3'd5;

    localparam int TARGET_SIDE_RST = 1500;
    localparam int P_GAIN_RST      = 16384;
    localparam int I_GAIN_RST      = 1638;
    localparam int D_GAIN_RST      = 1638;
    localparam int BASE_SPEED_RST  = 1000;
    localparam int FRONT_WALL_RST  = 2350;
    localparam int PULSE_RST       = 500;

    localparam logic [REPLY_W-1:0] REPLY_NONE  = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_START = 2'd1;
    localparam logic [REPLY_W-1:0] REPLY_STOP  = 2'd2;
    localparam logic [REPLY_W-1:0] REPLY_WRONG = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_G  = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_O  = 8'h4F;
    localparam logic [CHAR_W-1:0] CHAR_S  = 8'h53;
    localparam logic [CHAR_W-1:0] CHAR_T  = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [LIMIT_W-1:0] SIDE_WIN_LO    = 16'd1100;
    localparam logic [LIMIT_W-1:0] SIDE_WIN_HI    = 16'd2700;
    localparam logic [LIMIT_W-1:0] TURN_END_FRONT = 16'd1300;
    localparam logic [LIMIT_W-1:0] TURN_END_SIDE  = 16'd1800;

    localparam int CORR_MAX      = 2047;
    localparam int CORR_MIN      = -2048;
    localparam int BAND_LEFT_LO  = -100;
    localparam int BAND_LEFT_HI  = -15;
    localparam int BAND_SMALL_LO = 5;
    localparam int BAND_SMALL_HI = 40;

    localparam int K_RIGHT_WALL_Q8 = 1408;
    localparam int K_LEFT_WALL_Q8  = 4301;
    localparam int K_RIGHT_TURN    = 9;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_MUL_EP     = 4'd1,
        OP_MUL_EI     = 4'd2,
        OP_MUL_PP     = 4'd3,
        OP_MUL_II     = 4'd4,
        OP_MUL_DD     = 4'd5,
        OP_SUM        = 4'd6,
        OP_CORR       = 4'd7,
        OP_BAND       = 4'd8,
        OP_STEER      = 4'd9,
        OP_CMD        = 4'd10,
        OP_TURN_CHECK = 4'd11
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
        logic   publish;
    } dp_cmd_t;

    typedef struct packed {
        logic func;
        logic active;
        logic turning;
        logic out_busy;
    } dp_sts_t;

endpackage

### hw/rtl/wall_follow_motor_controller_unit.sv
// A command word, an idle tick and a turning tick pass from dispatch straight to
// the finish state, which waits while the output word is untaken; a steering tick
// first runs the multiply, sum, correction, band and steer states. A new word is taken
// only once the last result is published; the steering path runs six products through one multiplier.
// Reset (aresetn low, synchronous): registers to defaults, block stopped,
// wheels off, pulse widths 500, no word pending.
`timescale 1ns / 1ps

module wall_follow_motor_controller_unit #(
    parameter int SENSOR_BITS = wfmc_pkg::SENSOR_BITS_DEF,
    parameter int SPEED_BITS  = wfmc_pkg::SPEED_BITS_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // side_reading, front_reading, first_char, second_char
    input  logic [((2*SENSOR_BITS+16+7)/8)*8-1:0]             s_tdata,
    // func
    input  logic                                              s_tuser,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // left_speed, right_speed, left_on, right_on, left_reverse, reply,
    // correction, side_error
    output logic [((2*SPEED_BITS+SENSOR_BITS+18+7)/8)*8-1:0]  m_tdata,
    input  logic                                              cfg_wr_en,
    input  logic [wfmc_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [wfmc_pkg::CFG_DATA_W-1:0]                   cfg_data
);
    import wfmc_pkg::*;

    localparam int IN_W  = ((2 * SENSOR_BITS + 16 + 7) / 8) * 8;
    localparam int OUT_W = ((2 * SPEED_BITS + SENSOR_BITS + 18 + 7) / 8) * 8;

    dp_cmd_t cmd;
    dp_sts_t sts;

    wfmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wfmc_dp #(
        .SENSOR_BITS (SENSOR_BITS),
        .SPEED_BITS  (SPEED_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### hw/rtl/wfmc_ctrl.sv
`timescale 1ns / 1ps

module wfmc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wfmc_pkg::dp_sts_t sts,
    output wfmc_pkg::dp_cmd_t cmd
);
    import wfmc_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DISPATCH = 12'b0000_0000_0010,
        S_MUL_EP   = 12'b0000_0000_0100,
        S_MUL_EI   = 12'b0000_0000_1000,
        S_MUL_PP   = 12'b0000_0001_0000,
        S_MUL_II   = 12'b0000_0010_0000,
        S_MUL_DD   = 12'b0000_0100_0000,
        S_SUM      = 12'b0000_1000_0000,
        S_CORR     = 12'b0001_0000_0000,
        S_BAND     = 12'b0010_0000_0000,
        S_STEER    = 12'b0100_0000_0000,
        S_FINISH   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.publish = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.func) begin
                    cmd.op     = OP_CMD;
                    state_next = S_FINISH;
                end else if (!sts.active) begin
                    state_next = S_FINISH;
                end else if (sts.turning) begin
                    cmd.op     = OP_TURN_CHECK;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_MUL_EP;
                end
            end
            S_MUL_EP: begin
                cmd.op     = OP_MUL_EP;
                state_next = S_MUL_EI;
            end
            S_MUL_EI: begin
                cmd.op     = OP_MUL_EI;
                state_next = S_MUL_PP;
            end
            S_MUL_PP: begin
                cmd.op     = OP_MUL_PP;
                state_next = S_MUL_II;
            end
            S_MUL_II: begin
                cmd.op     = OP_MUL_II;
                state_next = S_MUL_DD;
            end
            S_MUL_DD: begin
                cmd.op     = OP_MUL_DD;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.op     = OP_SUM;
                state_next = S_CORR;
            end
            S_CORR: begin
                cmd.op     = OP_CORR;
                state_next = S_BAND;
            end
            S_BAND: begin
                cmd.op     = OP_BAND;
                state_next = S_STEER;
            end
            S_STEER: begin
                cmd.op     = OP_STEER;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !sts.out_busy)
        else $error("result word published over an untaken one");

    a_load_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_DISPATCH))
        else $error("accepted word not dispatched");
`endif

endmodule

### hw/rtl/wfmc_dp.sv
`timescale 1ns / 1ps

module wfmc_dp #(
    parameter int SENSOR_BITS = wfmc_pkg::SENSOR_BITS_DEF,
    parameter int SPEED_BITS  = wfmc_pkg::SPEED_BITS_DEF,
    parameter int IN_W        = ((2 * SENSOR_BITS + 16 + 7) / 8) * 8,
    parameter int OUT_W       = ((2 * SPEED_BITS + SENSOR_BITS + 18 + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [IN_W-1:0]                     s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_wr_en,
    input  logic [wfmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wfmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_W-1:0]                    m_tdata,
    input  wfmc_pkg::dp_cmd_t                   cmd,
    output wfmc_pkg::dp_sts_t                   sts
);
    import wfmc_pkg::*;

    localparam int SB        = SENSOR_BITS;
    localparam int SPB       = SPEED_BITS;
    localparam int E         = SB + 1;
    localparam int DW        = E + 1;
    localparam int MA_W      = (DW > CORR_W) ? DW : CORR_W;
    localparam int MB_W      = GAIN_W + 1;
    localparam int PW        = MA_W + MB_W;
    localparam int AW        = PW + 2;
    localparam int SPEED_MAX = (1 << SPB) - 1;

    // configuration
    logic [SB-1:0]     target_reg;
    logic [GAIN_W-1:0] p_gain_reg;
    logic [GAIN_W-1:0] i_gain_reg;
    logic [GAIN_W-1:0] d_gain_reg;
    logic [SPB-1:0]    base_reg;
    logic [SB-1:0]     front_level_reg;

    // latched word
    logic              func_reg;
    logic [SB-1:0]     side_reg;
    logic [SB-1:0]     front_reg;
    logic [CHAR_W-1:0] c0_reg;
    logic [CHAR_W-1:0] c1_reg;
    logic signed [E-1:0] err_reg;

    // scratch
    logic signed [E-1:0]      pv_reg;
    logic signed [E-1:0]      iv_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [AW-1:0]     acc_reg;
    logic signed [CORR_W-1:0] corr_reg;

    // block state
    logic                active_reg, active_next;
    logic                turning_reg, turning_next;
    logic                left_backward_reg, left_backward_next;
    logic                left_enabled_reg, left_enabled_next;
    logic                right_enabled_reg, right_enabled_next;
    logic [SPB-1:0]      left_pulse_reg, left_pulse_next;
    logic [SPB-1:0]      right_pulse_reg, right_pulse_next;
    logic signed [E-1:0] prev_err_reg, prev_err_next;
    logic [REPLY_W-1:0]  reply_reg, reply_next;
    logic                steered_reg, steered_next;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [DW-1:0]     dv;
    logic signed [PW-1:0]     prod_bias16;
    logic signed [PW-1:0]     prod_bias8;
    logic signed [PW-17:0]    prod_q16;
    logic signed [PW-9:0]     prod_q8;
    logic signed [AW-1:0]     acc_bias;
    logic signed [AW-17:0]    acc_q;
    logic signed [CORR_W-1:0] corr_sat;
    logic                     band_left;
    logic                     band_small;
    logic                     band_big;
    logic signed [PW-1:0]     delta;
    logic signed [PW-1:0]     base_ext;
    logic signed [PW-1:0]     left_calc;
    logic signed [PW-1:0]     right_calc;
    logic                     turn_end;
    logic                     turn_start;
    logic signed [E-1:0]      err_out;

    function automatic logic [SPB-1:0] clamp_pulse(input logic signed [PW-1:0] v);
        logic [SPB-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > PW'(SPEED_MAX)) begin
            r = SPB'(SPEED_MAX);
        end else begin
            r = v[SPB-1:0];
        end
        return r;
    endfunction

    assign dv = DW'(err_reg) - DW'(prev_err_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_EP: begin
                mul_a = MA_W'(err_reg);
                mul_b = signed'({1'b0, p_gain_reg});
            end
            OP_MUL_EI: begin
                mul_a = MA_W'(err_reg);
                mul_b = signed'({1'b0, i_gain_reg});
            end
            OP_MUL_PP: begin
                mul_a = MA_W'(pv_reg);
                mul_b = signed'({1'b0, p_gain_reg});
            end
            OP_MUL_II: begin
                mul_a = MA_W'(iv_reg);
                mul_b = signed'({1'b0, i_gain_reg});
            end
            OP_MUL_DD: begin
                mul_a = MA_W'(dv);
                mul_b = signed'({1'b0, d_gain_reg});
            end
            OP_BAND: begin
                mul_a = MA_W'(corr_reg);
                if (band_left) begin
                    mul_b = MB_W'(K_RIGHT_WALL_Q8);
                end else if (band_small) begin
                    mul_b = MB_W'(K_LEFT_WALL_Q8);
                end else if (band_big) begin
                    mul_b = MB_W'(K_RIGHT_TURN);
                end
            end
            default: begin
            end
        endcase
    end

    // truncate toward zero
    assign prod_bias16 = prod_reg + (prod_reg[PW-1] ? PW'(65535) : PW'(0));
    assign prod_q16    = prod_bias16[PW-1:16];
    assign prod_bias8  = prod_reg + (prod_reg[PW-1] ? PW'(255) : PW'(0));
    assign prod_q8     = prod_bias8[PW-1:8];
    assign acc_bias    = acc_reg + (acc_reg[AW-1] ? AW'(65535) : AW'(0));
    assign acc_q       = acc_bias[AW-1:16];

    always_comb begin
        if (acc_q > CORR_MAX) begin
            corr_sat = CORR_W'(CORR_MAX);
        end else if (acc_q < CORR_MIN) begin
            corr_sat = CORR_W'(CORR_MIN);
        end else begin
            corr_sat = acc_q[CORR_W-1:0];
        end
    end

    assign band_left  = (corr_reg <= BAND_LEFT_HI) && (corr_reg >= BAND_LEFT_LO);
    assign band_small = (corr_reg >= BAND_SMALL_LO) && (corr_reg <= BAND_SMALL_HI);
    assign band_big   = (corr_reg > BAND_SMALL_HI);

    assign delta      = (band_left || band_small) ? PW'(prod_q8) : prod_reg;
    assign base_ext   = signed'(PW'(base_reg));
    assign left_calc  = base_ext + (band_left ? delta : PW'(0));
    assign right_calc = base_ext - ((band_small || band_big) ? delta : PW'(0));

    assign turn_end   = (LIMIT_W'(front_reg) <= TURN_END_FRONT)
                     && (LIMIT_W'(side_reg) <= TURN_END_SIDE);
    assign turn_start = (front_reg >= front_level_reg)
                     && (LIMIT_W'(side_reg) >= SIDE_WIN_LO)
                     && (LIMIT_W'(side_reg) <= SIDE_WIN_HI);

    always_comb begin
        active_next        = active_reg;
        turning_next       = turning_reg;
        left_backward_next = left_backward_reg;
        left_enabled_next  = left_enabled_reg;
        right_enabled_next = right_enabled_reg;
        left_pulse_next    = left_pulse_reg;
        right_pulse_next   = right_pulse_reg;
        prev_err_next      = prev_err_reg;
        reply_next         = reply_reg;
        steered_next       = steered_reg;
        if (cmd.load) begin
            reply_next   = REPLY_NONE;
            steered_next = 1'b0;
        end
        case (cmd.op)
            OP_CMD: begin
                if (c0_reg == CHAR_G && c1_reg == CHAR_O) begin
                    active_next = 1'b1;
                    reply_next  = REPLY_START;
                end else if (c0_reg == CHAR_S && c1_reg == CHAR_T) begin
                    active_next        = 1'b0;
                    left_enabled_next  = 1'b0;
                    right_enabled_next = 1'b0;
                    turning_next       = 1'b0;
                    left_backward_next = 1'b0;
                    reply_next         = REPLY_STOP;
                end else if (c0_reg == CHAR_CR && c1_reg == CHAR_LF) begin
                    reply_next = REPLY_NONE;
                end else begin
                    reply_next = REPLY_WRONG;
                end
            end
            OP_TURN_CHECK: begin
                if (turn_end) begin
                    turning_next       = 1'b0;
                    left_backward_next = 1'b0;
                end
            end
            OP_STEER: begin
                left_pulse_next    = clamp_pulse(left_calc);
                right_pulse_next   = clamp_pulse(right_calc);
                left_enabled_next  = 1'b1;
                right_enabled_next = 1'b1;
                prev_err_next      = err_reg;
                steered_next       = 1'b1;
                if (turn_start) begin
                    left_pulse_next    = base_reg;
                    right_pulse_next   = base_reg;
                    turning_next       = !turn_end;
                    left_backward_next = !turn_end;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg        <= SB'(TARGET_SIDE_RST);
            p_gain_reg        <= GAIN_W'(P_GAIN_RST);
            i_gain_reg        <= GAIN_W'(I_GAIN_RST);
            d_gain_reg        <= GAIN_W'(D_GAIN_RST);
            base_reg          <= SPB'(BASE_SPEED_RST);
            front_level_reg   <= SB'(FRONT_WALL_RST);
            active_reg        <= 1'b0;
            turning_reg       <= 1'b0;
            left_backward_reg <= 1'b0;
            left_enabled_reg  <= 1'b0;
            right_enabled_reg <= 1'b0;
            left_pulse_reg    <= SPB'(PULSE_RST);
            right_pulse_reg   <= SPB'(PULSE_RST);
            prev_err_reg      <= '0;
            reply_reg         <= REPLY_NONE;
            steered_reg       <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TARGET_SIDE:      target_reg      <= cfg_data[SB-1:0];
                    CFG_P_GAIN:           p_gain_reg      <= cfg_data[GAIN_W-1:0];
                    CFG_I_GAIN:           i_gain_reg      <= cfg_data[GAIN_W-1:0];
                    CFG_D_GAIN:           d_gain_reg      <= cfg_data[GAIN_W-1:0];
                    CFG_BASE_SPEED:       base_reg        <= cfg_data[SPB-1:0];
                    CFG_FRONT_WALL_LEVEL: front_level_reg <= cfg_data[SB-1:0];
                    default: begin
                    end
                endcase
            end
            active_reg        <= active_next;
            turning_reg       <= turning_next;
            left_backward_reg <= left_backward_next;
            left_enabled_reg  <= left_enabled_next;
            right_enabled_reg <= right_enabled_next;
            left_pulse_reg    <= left_pulse_next;
            right_pulse_reg   <= right_pulse_next;
            prev_err_reg      <= prev_err_next;
            reply_reg         <= reply_next;
            steered_reg       <= steered_next;
            if (cmd.publish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign err_out = steered_reg ? err_reg : E'(0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tuser;
            side_reg  <= s_tdata[SB-1:0];
            front_reg <= s_tdata[2*SB-1:SB];
            c0_reg    <= s_tdata[2*SB+CHAR_W-1:2*SB];
            c1_reg    <= s_tdata[2*SB+2*CHAR_W-1:2*SB+CHAR_W];
            err_reg   <= signed'({1'b0, target_reg}) - signed'({1'b0, s_tdata[SB-1:0]});
            corr_reg  <= '0;
        end
        case (cmd.op)
            OP_MUL_EP, OP_MUL_DD, OP_BAND: begin
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_EI: begin
                pv_reg   <= E'(prod_q16);
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_PP: begin
                iv_reg   <= E'(prod_q16);
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_II: begin
                acc_reg  <= AW'(prod_reg);
                prod_reg <= mul_a * mul_b;
            end
            OP_SUM: begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
            OP_CORR: begin
                corr_reg <= corr_sat;
            end
            default: begin
            end
        endcase
        if (cmd.op == OP_MUL_DD) begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
        if (cmd.publish) begin
            out_data_reg <= OUT_W'({err_out, corr_reg, reply_reg, left_backward_reg,
                                    right_enabled_reg, left_enabled_reg,
                                    right_pulse_reg, left_pulse_reg});
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = out_data_reg;
    assign sts.func     = func_reg;
    assign sts.active   = active_reg;
    assign sts.turning  = turning_reg;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

`ifndef NO_ASSERTIONS
    a_turn_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        turning_reg == left_backward_reg)
        else $error("turn flag and reverse flag disagree");

    a_turn_active: assert property (@(posedge aclk) disable iff (!aresetn)
        turning_reg |-> active_reg)
        else $error("turning while stopped");

    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_tvalid_reg)
        else $error("published word not presented");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wfmc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 115;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic        func;
        logic [11:0] side;
        logic [11:0] front;
        logic [7:0]  c0;
        logic [7:0]  c1;
    } drive_word_t;

    typedef struct packed {
        logic signed [12:0] side_error;
        logic signed [11:0] correction;
        logic [1:0]         reply;
        logic               left_reverse;
        logic               right_on;
        logic               left_on;
        logic [9:0]         right_speed;
        logic [9:0]         left_speed;
    } wheel_word_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    drive_word_t pending_q[$];
    wheel_word_t wheel_q[$];
    int          items_sent  = 0;
    int          items_taken = 0;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          s_gap       = 0;
    int          m_gap       = 0;
    bit          idle_on     = 1'b1;
    logic        in_taken    = 1'b0;
    int          ph_target   = TARGET_SIDE_RST;
    int          ph_level    = FRONT_WALL_RST;

    // controller model state and registers
    int  tgt_side, kp, ki, kd, base_pw, wall_level;
    bit  drive_active, u_turn, left_en, right_en, left_back;
    int  prev_err, left_pw, right_pw;

    wall_follow_motor_controller_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pw_sat(longint v);
        if (v < 0) return 0;
        if (v > 1023) return 1023;
        return int'(v);
    endfunction

    function automatic string word_text(wheel_word_t v);
        return $sformatf("ls=%0d rs=%0d on=%b%b rev=%b rep=%0d corr=%0d err=%0d",
                         v.left_speed, v.right_speed, v.left_on, v.right_on,
                         v.left_reverse, v.reply, v.correction, v.side_error);
    endfunction

    function automatic wheel_word_t steer_step(drive_word_t w);
        wheel_word_t r;
        longint err, pv, iv, dv, sum, corr, base, s, f;
        r = '0;
        err = 0;
        corr = 0;
        s = longint'(w.side);
        f = longint'(w.front);
        base = longint'(base_pw);
        if (w.func) begin
            if (w.c0 == CHAR_G && w.c1 == CHAR_O) begin
                drive_active = 1'b1;
                r.reply = REPLY_START;
            end else if (w.c0 == CHAR_S && w.c1 == CHAR_T) begin
                drive_active = 1'b0;
                left_en = 1'b0;
                right_en = 1'b0;
                u_turn = 1'b0;
                left_back = 1'b0;
                r.reply = REPLY_STOP;
            end else if (w.c0 == CHAR_CR && w.c1 == CHAR_LF) begin
                r.reply = REPLY_NONE;
            end else begin
                r.reply = REPLY_WRONG;
            end
        end else if (drive_active) begin
            if (u_turn) begin
                if (f <= longint'(TURN_END_FRONT) && s <= longint'(TURN_END_SIDE)) begin
                    u_turn = 1'b0;
                    left_back = 1'b0;
                end
            end else begin
                err = longint'(tgt_side) - s;
                pv = (err * longint'(kp)) / 65536;
                iv = (err * longint'(ki)) / 65536;
                dv = err - longint'(prev_err);
                sum = pv * longint'(kp) + iv * longint'(ki) + dv * longint'(kd);
                corr = sum / 65536;
                if (corr > CORR_MAX) corr = CORR_MAX;
                if (corr < CORR_MIN) corr = CORR_MIN;
                if (corr <= BAND_LEFT_HI && corr >= BAND_LEFT_LO) begin
                    right_pw = pw_sat(base);
                    left_pw = pw_sat(base + (K_RIGHT_WALL_Q8 * corr) / 256);
                end else if (corr >= BAND_SMALL_LO && corr <= BAND_SMALL_HI) begin
                    left_pw = pw_sat(base);
                    right_pw = pw_sat(base - (K_LEFT_WALL_Q8 * corr) / 256);
                end else if (corr > BAND_SMALL_HI) begin
                    left_pw = pw_sat(base);
                    right_pw = pw_sat(base - K_RIGHT_TURN * corr);
                end else begin
                    left_pw = pw_sat(base);
                    right_pw = pw_sat(base);
                end
                left_en = 1'b1;
                right_en = 1'b1;
                prev_err = int'(err);
                if (f >= longint'(wall_level) && s >= longint'(SIDE_WIN_LO)
                        && s <= longint'(SIDE_WIN_HI)) begin
                    left_back = 1'b1;
                    left_pw = pw_sat(base);
                    right_pw = pw_sat(base);
                    u_turn = 1'b1;
                    if (f <= longint'(TURN_END_FRONT) && s <= longint'(TURN_END_SIDE)) begin
                        u_turn = 1'b0;
                        left_back = 1'b0;
                    end
                end
            end
        end
        r.left_speed = left_pw[9:0];
        r.right_speed = right_pw[9:0];
        r.left_on = left_en;
        r.right_on = right_en;
        r.left_reverse = left_back;
        r.correction = corr[11:0];
        r.side_error = err[12:0];
        return r;
    endfunction

    // input side: hold until taken, idle in bursts
    always @(negedge aclk) begin : drive_in
        logic        nv;
        drive_word_t w;
        nv = s_tvalid && !in_taken;
        if (aresetn && !nv) begin
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                s_gap = $urandom_range(0, 12);
            end else if (pending_q.size() != 0) begin
                w = pending_q.pop_front();
                s_tdata <= {w.c1, w.c0, w.front, w.side};
                s_tuser <= w.func;
                items_sent = items_sent + 1;
                nv = 1'b1;
            end
        end
        s_tvalid <= nv;
    end

    always @(negedge aclk) begin : drive_out
        logic nr;
        nr = 1'b1;
        if (aresetn && idle_on) begin
            if (m_gap > 0) begin
                m_gap = m_gap - 1;
                nr = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                m_gap = $urandom_range(0, 12);
                nr = 1'b0;
            end
        end
        m_tready <= nr;
    end

    always @(posedge aclk) begin : watch
        wheel_word_t want;
        wheel_word_t got;
        drive_word_t w;
        if (!aresetn) begin
            tgt_side = TARGET_SIDE_RST;
            kp = P_GAIN_RST;
            ki = I_GAIN_RST;
            kd = D_GAIN_RST;
            base_pw = BASE_SPEED_RST;
            wall_level = FRONT_WALL_RST;
            drive_active = 1'b0;
            u_turn = 1'b0;
            left_en = 1'b0;
            right_en = 1'b0;
            left_back = 1'b0;
            prev_err = 0;
            left_pw = PULSE_RST;
            right_pw = PULSE_RST;
            in_taken <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TARGET_SIDE:      tgt_side = int'(cfg_data[11:0]);
                    CFG_P_GAIN:           kp = int'(cfg_data);
                    CFG_I_GAIN:           ki = int'(cfg_data);
                    CFG_D_GAIN:           kd = int'(cfg_data);
                    CFG_BASE_SPEED:       base_pw = int'(cfg_data[9:0]);
                    CFG_FRONT_WALL_LEVEL: wall_level = int'(cfg_data[11:0]);
                    default: ;
                endcase
            end
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                w.func = s_tuser;
                w.side = s_tdata[11:0];
                w.front = s_tdata[23:12];
                w.c0 = s_tdata[31:24];
                w.c1 = s_tdata[39:32];
                items_taken = items_taken + 1;
                wheel_q.push_back(steer_step(w));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[49:0];
                if (wheel_q.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected word %h at cycle %0d", got, cycle_count);
                end else begin
                    want = wheel_q.pop_front();
                    if (got !== want) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("mismatch at cycle %0d: want %s / got %s", cycle_count,
                                     word_text(want), word_text(got));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic settle();
        while (pending_q.size() != 0 || items_taken != items_sent || wheel_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic program_phase(int t, int p, int i, int d, int b, int l);
        settle();
        write_reg(CFG_TARGET_SIDE, 16'(t) | 16'($urandom_range(0, 15) << 12));
        write_reg(CFG_P_GAIN, 16'(p));
        write_reg(CFG_I_GAIN, 16'(i));
        write_reg(CFG_D_GAIN, 16'(d));
        write_reg(CFG_BASE_SPEED, 16'(b) | 16'($urandom_range(0, 63) << 10));
        write_reg(CFG_FRONT_WALL_LEVEL, 16'(l) | 16'($urandom_range(0, 15) << 12));
        write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        ph_target = t;
        ph_level = l;
    endtask

    task automatic push_tick(int side, int front);
        drive_word_t w;
        w.func = 1'b0;
        w.side = 12'(side);
        w.front = 12'(front);
        w.c0 = 8'($urandom_range(0, 255));
        w.c1 = 8'($urandom_range(0, 255));
        pending_q.push_back(w);
    endtask

    task automatic push_cmd(logic [7:0] c0, logic [7:0] c1);
        drive_word_t w;
        w.func = 1'b1;
        w.side = 12'($urandom_range(0, 4095));
        w.front = 12'($urandom_range(0, 4095));
        w.c0 = c0;
        w.c1 = c1;
        pending_q.push_back(w);
    endtask

    initial begin
        int ph, n, sel, sd, fr;
        bit go_first;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        program_phase(TARGET_SIDE_RST, P_GAIN_RST, I_GAIN_RST, D_GAIN_RST,
                      BASE_SPEED_RST, FRONT_WALL_RST);
        push_tick(0, 4095);
        push_cmd(CHAR_CR, CHAR_LF);
        push_cmd(CHAR_G, 8'h58);
        push_cmd(8'h00, 8'h00);
        push_cmd(8'hFF, 8'hFF);
        push_cmd(CHAR_S, CHAR_T);
        push_cmd(CHAR_G, CHAR_O);
        push_cmd(CHAR_G, CHAR_O);
        push_tick(1500, 0);
        push_tick(0, 0);
        push_tick(4095, 0);
        push_tick(1200, 0);
        push_tick(2000, 0);
        push_tick(1100, 2350);
        push_tick(2000, 2000);
        push_tick(1800, 1300);
        push_tick(2700, 4095);
        push_cmd(CHAR_S, CHAR_T);
        push_cmd(CHAR_G, CHAR_O);
        push_tick(1099, 4095);
        push_tick(2701, 4095);
        push_cmd(CHAR_CR, CHAR_LF);

        // wall level zero: turn starts and ends on the same tick
        program_phase(TARGET_SIDE_RST, P_GAIN_RST, I_GAIN_RST, D_GAIN_RST,
                      BASE_SPEED_RST, 0);
        push_tick(1500, 1000);
        push_tick(1700, 1300);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: program_phase(4095, 65535, 65535, 65535, 1023, 4095);
                1: program_phase(0, 0, 0, 0, 0, 0);
                2: program_phase(0, 65535, 65535, 65535, 1023, 2350);
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        sd = $urandom_range(0, 4095);
                    else
                        sd = $urandom_range(1000, 2200);
                    if ($urandom_range(0, 1) == 0)
                        program_phase(sd, $urandom_range(0, 65535), $urandom_range(0, 65535),
                                      $urandom_range(0, 65535), $urandom_range(0, 1023),
                                      $urandom_range(0, 4095));
                    else
                        program_phase(sd, $urandom_range(4000, 30000), $urandom_range(0, 8000),
                                      $urandom_range(0, 8000), $urandom_range(600, 1023),
                                      $urandom_range(1800, 3200));
                end
            endcase
            idle_on = (ph != 4 && ph != PHASES - 1);
            go_first = 1'($urandom_range(0, 1));
            for (n = 0; n < PHASE_WORDS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 82 && !(n == 0 && go_first)) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 4) begin
                        sd = ph_target + int'($urandom_range(0, 1400)) - 700;
                        if (sd < 0) sd = 0;
                        if (sd > 4095) sd = 4095;
                    end else if (sel < 7) begin
                        sd = $urandom_range(1100, 2700);
                    end else begin
                        sd = $urandom_range(0, 4095);
                    end
                    sel = $urandom_range(0, 9);
                    if (sel < 4) begin
                        fr = $urandom_range(0, 1300);
                    end else if (sel < 7) begin
                        fr = ph_level + int'($urandom_range(0, 400)) - 200;
                        if (fr < 0) fr = 0;
                        if (fr > 4095) fr = 4095;
                    end else begin
                        fr = $urandom_range(0, 4095);
                    end
                    push_tick(sd, fr);
                end else begin
                    sel = (n == 0) ? 0 : $urandom_range(0, 19);
                    if (sel < 8)
                        push_cmd(CHAR_G, CHAR_O);
                    else if (sel < 11)
                        push_cmd(CHAR_S, CHAR_T);
                    else if (sel < 14)
                        push_cmd(CHAR_CR, CHAR_LF);
                    else if (sel < 16)
                        push_cmd(CHAR_G, 8'($urandom_range(0, 255)));
                    else
                        push_cmd(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && wheel_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
